// File: sv/mpm_pkg.sv
package mpm_pkg;

  // channel storage
  localparam int unsigned MaxChannels = 8;
  localparam int unsigned ChW         = $clog2(MaxChannels);
  localparam int unsigned CntW        = 4;

  // field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned MagW    = 15;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // fixed values
  localparam logic [MagW-1:0]   MaxMag   = {MagW{1'b1}};
  localparam logic [TimerW-1:0] FullHold = {TimerW{1'b1}};

  // register reset values
  localparam logic [CntW-1:0]   CountRst     = CntW'(1);
  localparam logic [MagW-1:0]   LevelStepRst = MagW'(273);
  localparam logic [TimerW-1:0] HoldStepRst  = TimerW'(546);

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_COUNT      = 2'd0,
    REG_LEVEL_STEP = 2'd1,
    REG_HOLD_STEP  = 2'd2
  } reg_idx_e;

  // one stored channel
  typedef struct packed {
    logic [MagW-1:0]   level;
    logic [MagW-1:0]   peak;
    logic [TimerW-1:0] timer;
  } entry_t;

endpackage

// File: sv/multichannel_peak_meter_with_hold.sv
// Peak meter for up to eight interleaved audio channels, with peak hold.
// Input channel (in_valid_i/in_ready_o): mode_i 0 carries one sample in
// sample_value_i, routed to the rotating channel (buffer_start_i restarts
// the rotation at channel 0); mode_i 1 is a tick of one update interval.
// Output channel (out_valid_o/out_ready_i): a tick gives one item per
// channel in use, channel 0 first, last_channel_o set on the final one.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 channel count, 1 level decay step, 2 hold decay step).
// Timing: channel state sits in one memory with a registered read.
// A sample is read when it is accepted, then modified and written back
// in ST_SMP; no new sample is accepted until that is done. A tick walks
// the channels, reading each in ST_TRD, then decaying it, writing it
// back and loading the output register in ST_TWR, until the last one.
// Reset clears every channel to zero at once through per-entry valid
// bits, restarts the rotation and loads the register defaults.
// A single output register parts the sides: samples are still accepted
// while an item waits, and a walk pauses while the receiver stalls.
module multichannel_peak_meter_with_hold (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mpm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mpm_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic signed [mpm_pkg::SampleW-1:0] sample_value_i,
  input  logic                               buffer_start_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mpm_pkg::ChW-1:0]            channel_index_o,
  output logic [mpm_pkg::MagW-1:0]           running_level_o,
  output logic [mpm_pkg::MagW-1:0]           held_peak_o,
  output logic [mpm_pkg::TimerW-1:0]         hold_timer_o,
  output logic                               last_channel_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SMP  = 4'b0010,
    ST_TRD  = 4'b0100,
    ST_TWR  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [mpm_pkg::CntW-1:0]   count_q;
  logic [mpm_pkg::MagW-1:0]   lstep_q;
  logic [mpm_pkg::TimerW-1:0] hstep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= mpm_pkg::CountRst;
      lstep_q <= mpm_pkg::LevelStepRst;
      hstep_q <= mpm_pkg::HoldStepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mpm_pkg::REG_COUNT:      count_q <= cfg_wdata_i[mpm_pkg::CntW-1:0];
        mpm_pkg::REG_LEVEL_STEP: lstep_q <= cfg_wdata_i[mpm_pkg::MagW-1:0];
        mpm_pkg::REG_HOLD_STEP:  hstep_q <= cfg_wdata_i[mpm_pkg::TimerW-1:0];
        default: ;
      endcase
    end
  end

  // channels in use, clamped to 1..MaxChannels
  logic [mpm_pkg::CntW-1:0] n_use;
  always_comb begin
    if (count_q == '0) begin
      n_use = mpm_pkg::CntW'(1);
    end else if (count_q > mpm_pkg::CntW'(mpm_pkg::MaxChannels)) begin
      n_use = mpm_pkg::CntW'(mpm_pkg::MaxChannels);
    end else begin
      n_use = count_q;
    end
  end

  // sample magnitude with saturation
  logic [mpm_pkg::SampleW-1:0] neg_val;
  logic [mpm_pkg::MagW-1:0]    mag;
  always_comb begin
    neg_val = -sample_value_i;
    if (!sample_value_i[mpm_pkg::SampleW-1]) begin
      mag = sample_value_i[mpm_pkg::MagW-1:0];
    end else if (neg_val[mpm_pkg::SampleW-1]) begin
      mag = mpm_pkg::MaxMag;
    end else begin
      mag = neg_val[mpm_pkg::MagW-1:0];
    end
  end

  // channel rotation
  logic [mpm_pkg::ChW-1:0]  next_ch_q;
  logic [mpm_pkg::ChW-1:0]  smp_ch;
  logic [mpm_pkg::CntW-1:0] smp_inc;
  always_comb begin
    if (buffer_start_i || ({1'b0, next_ch_q} >= n_use)) begin
      smp_ch = '0;
    end else begin
      smp_ch = next_ch_q;
    end
    smp_inc = {1'b0, smp_ch} + mpm_pkg::CntW'(1);
  end

  logic in_acc;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // item under work
  logic [mpm_pkg::ChW-1:0]  cur_ch_q;
  logic [mpm_pkg::MagW-1:0] cur_mag_q;
  logic [mpm_pkg::CntW-1:0] ch_inc;
  logic                     walk_last;
  assign ch_inc    = {1'b0, cur_ch_q} + mpm_pkg::CntW'(1);
  assign walk_last = (ch_inc == n_use);

  // state memory and valid bits
  mpm_pkg::entry_t mem_q [mpm_pkg::MaxChannels];
  logic [mpm_pkg::MaxChannels-1:0] vld_q;
  logic [mpm_pkg::MaxChannels-1:0] chg_q;
  mpm_pkg::entry_t rdata_q;
  logic            rvld_q;
  logic            rd_en, wr_en;
  logic [mpm_pkg::ChW-1:0] rd_addr;
  mpm_pkg::entry_t rd_ent, wr_ent;

  assign rd_ent = rvld_q ? rdata_q : '0;

  logic slot_free;
  assign slot_free = !out_valid_o || out_ready_i;

  // read address and enable
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_ch_q;
    if (state_q == ST_IDLE && in_acc && !mode_i) begin
      rd_en   = 1'b1;
      rd_addr = smp_ch;
    end else if (state_q == ST_TRD) begin
      rd_en = 1'b1;
    end
  end

  // modify: sample update or tick decay
  always_comb begin
    wr_ent = rd_ent;
    wr_en  = 1'b0;
    if (state_q == ST_SMP) begin
      wr_en = 1'b1;
      if (rd_ent.level < cur_mag_q) begin
        wr_ent.level = cur_mag_q;
      end
      if (rd_ent.peak <= cur_mag_q) begin
        wr_ent.peak  = cur_mag_q;
        wr_ent.timer = mpm_pkg::FullHold;
      end
    end else if (state_q == ST_TWR) begin
      wr_en = slot_free;
      if (!chg_q[cur_ch_q]) begin
        wr_ent.level = (rd_ent.level > lstep_q) ? rd_ent.level - lstep_q : '0;
      end
      if (rd_ent.timer != '0) begin
        if (rd_ent.timer > hstep_q) begin
          wr_ent.timer = rd_ent.timer - hstep_q;
        end else begin
          wr_ent.timer = '0;
          wr_ent.peak  = '0;
        end
      end
    end
  end

  // memory array, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cur_ch_q] <= wr_ent;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // valid bits, changed marks, read valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      chg_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rvld_q <= vld_q[rd_addr];
      end
      if (wr_en) begin
        vld_q[cur_ch_q] <= 1'b1;
      end
      if (state_q == ST_SMP && rd_ent.level < cur_mag_q) begin
        chg_q[cur_ch_q] <= 1'b1;
      end else if (state_q == ST_TWR && slot_free) begin
        chg_q[cur_ch_q] <= 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = mode_i ? ST_TRD : ST_SMP;
        end
      end
      ST_SMP:  state_d = ST_IDLE;
      ST_TRD:  state_d = ST_TWR;
      ST_TWR: begin
        if (slot_free) begin
          state_d = walk_last ? ST_IDLE : ST_TRD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      next_ch_q <= '0;
      cur_ch_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (mode_i) begin
          cur_ch_q <= '0;
        end else begin
          cur_ch_q  <= smp_ch;
          next_ch_q <= (smp_inc >= n_use) ? '0 : smp_inc[mpm_pkg::ChW-1:0];
        end
      end else if (state_q == ST_TWR && slot_free && !walk_last) begin
        cur_ch_q <= ch_inc[mpm_pkg::ChW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_mag_q <= mag;
    end
  end

  // output register
  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_TWR && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_TWR && slot_free) begin
      channel_index_o <= cur_ch_q;
      running_level_o <= wr_ent.level;
      held_peak_o     <= wr_ent.peak;
      hold_timer_o    <= wr_ent.timer;
      last_channel_o  <= walk_last;
    end
  end

endmodule

// File: sv/mpm_checker.sv
module mpm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               mode_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [mpm_pkg::ChW-1:0]            channel_index_o,
  input logic [mpm_pkg::MagW-1:0]           held_peak_o,
  input logic [mpm_pkg::TimerW-1:0]         hold_timer_o,
  input logic                               last_channel_o
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(channel_index_o)
      && $stable(held_peak_o) && $stable(last_channel_o))
    else $error("stalled output item changed");

  // a sample is read, then written back, so no item is taken right after one
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !mode_i |=> !in_ready_o)
    else $error("input taken during sample update");

  // a tick walk blocks input while it runs
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i |=> !in_ready_o)
    else $error("input taken during channel walk");

  // an expired hold never shows a peak
  a_peak_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hold_timer_o == '0 |-> held_peak_o == '0)
    else $error("held peak without running hold timer");

endmodule

bind multichannel_peak_meter_with_hold mpm_checker u_mpm_checker (.*);
